### rtl/buddy_block_allocator_assert.svh
// Assertion macros used by the buddy block allocator engine.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");

`endif

### rtl/bba_pkg.sv
// Types and constants of the buddy block allocator.
package bba_pkg;

    localparam int SIZE_W     = 24;
    localparam int INDEX_W    = 8;
    localparam int OFFSET_W   = 23;
    localparam int LEVEL_W    = 3;
    localparam int MBS_W      = 16;
    localparam int NL_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 1'b1;

    localparam logic [MBS_W-1:0] MBS_RESET = 16'd16;
    localparam logic [NL_W-1:0]  NL_RESET  = 4'd8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [INDEX_W-1:0]    node_index;
        logic [OFFSET_W-1:0]   user_offset;
        logic [LEVEL_W-1:0]    block_level;
    } t_result;

    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

### rtl/bba_engine.sv
// Buddy allocator sequencer around the free-bit map memory.
module bba_engine
    import bba_pkg::*;
#(
    parameter int MAX_LEVELS   = 8,
    parameter int HEADER_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_eng_ctl            i_ctl,
    input  logic                i_command,
    input  logic [SIZE_W-1:0]   i_request_size,
    input  logic [INDEX_W-1:0]  i_free_index,
    input  logic [MBS_W-1:0]    i_min_block_size,
    input  logic [NL_W-1:0]     i_num_levels,
    output t_eng_stat           o_stat,
    output t_result             o_result
);

`include "buddy_block_allocator_assert.svh"

    localparam int IW    = MAX_LEVELS;
    localparam int NODES = (1 << MAX_LEVELS) - 1;
    localparam int LVW   = $clog2(MAX_LEVELS + 1);
    localparam int CURW  = MBS_W + MAX_LEVELS;
    localparam int TOTW  = SIZE_W + 1;
    localparam int CMPW  = (CURW > TOTW) ? CURW : TOTW;
    localparam int FIW   = ((MAX_LEVELS > INDEX_W) ? MAX_LEVELS : INDEX_W) + 1;
    localparam int NLCW  = (NL_W > LVW) ? NL_W : LVW;
    localparam int PW    = IW + OFFSET_W;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_SIZE     = 14'b00000000000100,
        S_SCAN     = 14'b00000000001000,
        S_SPLIT_A  = 14'b00000000010000,
        S_SPLIT_B  = 14'b00000000100000,
        S_OFFSET   = 14'b00000001000000,
        S_ADD      = 14'b00000010000000,
        S_FREE_W   = 14'b00000100000000,
        S_FREE_RD  = 14'b00001000000000,
        S_FREE_CHK = 14'b00010000000000,
        S_MERGE_A  = 14'b00100000000000,
        S_MERGE_B  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } t_state;

    function automatic logic [IW-1:0] first_at(input logic [LVW-1:0] l);
        logic [IW:0] t;
        t = ((IW+1)'(1) << l) - (IW+1)'(1);
        return t[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] last_at(input logic [LVW-1:0] l);
        logic [IW:0] t;
        t = ((IW+1)'(1) << (l + LVW'(1))) - (IW+1)'(2);
        return t[IW-1:0];
    endfunction

    // free-bit map, one port, read-first
    logic r_map [0:NODES-1];
    logic r_rdata;
    logic [IW-1:0] mem_addr;
    logic mem_we;
    logic mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_map[mem_addr];
    end

    t_state r_state, n_state;
    logic [TOTW-1:0] r_total, n_total;
    logic [CURW-1:0] r_cur, n_cur;
    logic [LVW-1:0] r_lvl, n_lvl;
    logic [LVW-1:0] r_k, n_k;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_scan_addr, n_scan_addr;
    logic r_scan_on, n_scan_on;
    logic r_chk_valid, n_chk_valid;
    logic [IW-1:0] r_chk_addr, n_chk_addr;
    logic [LVW-1:0] r_chk_lvl, n_chk_lvl;
    logic [IW-1:0] r_clr, n_clr;
    logic [OFFSET_W-1:0] r_prod, n_prod;
    t_result r_res, n_res;

    logic [LVW-1:0] eff_lv;
    logic [MBS_W-1:0] unit;
    logic [FIW-1:0] fi_ext;
    logic [FIW-1:0] first_n;
    logic [IW-1:0] buddy;
    logic [IW-1:0] parent;
    logic [IW-1:0] left;
    logic [IW-1:0] pos;
    logic [PW-1:0] prod_full;

    always_comb begin
        if (i_num_levels == '0) begin
            eff_lv = LVW'(1);
        end else if (NLCW'(i_num_levels) > NLCW'(MAX_LEVELS)) begin
            eff_lv = LVW'(MAX_LEVELS);
        end else begin
            eff_lv = LVW'(i_num_levels);
        end
    end

    assign unit      = (i_min_block_size == '0) ? MBS_W'(1) : i_min_block_size;
    assign fi_ext    = FIW'(i_free_index);
    assign first_n   = (FIW'(1) << eff_lv) - FIW'(1);
    assign buddy     = r_idx[0] ? (r_idx + IW'(1)) : (r_idx - IW'(1));
    assign parent    = (r_idx - IW'(1)) >> 1;
    assign left      = IW'({r_idx, 1'b1});
    assign pos       = r_idx - first_at(r_lvl);
    assign prod_full = PW'(pos) * PW'(r_cur[((CURW < OFFSET_W) ? CURW : OFFSET_W)-1:0]);

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_cur       = r_cur;
        n_lvl       = r_lvl;
        n_k         = r_k;
        n_idx       = r_idx;
        n_scan_addr = r_scan_addr;
        n_scan_on   = r_scan_on;
        n_chk_valid = r_chk_valid;
        n_chk_addr  = r_chk_addr;
        n_chk_lvl   = r_chk_lvl;
        n_clr       = r_clr;
        n_prod      = r_prod;
        n_res       = r_res;
        mem_addr    = r_idx;
        mem_we      = 1'b0;
        mem_wdata   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_addr  = r_clr;
                mem_we    = 1'b1;
                mem_wdata = (r_clr == '0);
                if (r_clr == IW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + IW'(1);
                end
            end
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_res = '0;
                    if (i_command == CMD_ALLOC) begin
                        n_total = TOTW'(i_request_size) + TOTW'(HEADER_BYTES);
                        n_cur   = CURW'(unit);
                        n_lvl   = eff_lv - LVW'(1);
                        n_state = S_SIZE;
                    end else if (fi_ext >= first_n) begin
                        n_res.status = ST_BAD_INDEX;
                        n_state      = S_DONE;
                    end else begin
                        n_idx   = fi_ext[IW-1:0];
                        n_state = S_FREE_W;
                    end
                end
            end
            S_SIZE: begin
                if (CMPW'(r_cur) >= CMPW'(r_total)) begin
                    n_k         = r_lvl;
                    n_scan_addr = first_at(r_lvl);
                    n_scan_on   = 1'b1;
                    n_chk_valid = 1'b0;
                    n_state     = S_SCAN;
                end else if (r_lvl == '0) begin
                    n_res.status = ST_TOO_LARGE;
                    n_state      = S_DONE;
                end else begin
                    n_lvl = r_lvl - LVW'(1);
                    n_cur = r_cur << 1;
                end
            end
            S_SCAN: begin
                // one read issued per cycle, checked in the cycle after
                n_chk_valid = r_scan_on;
                n_chk_addr  = r_scan_addr;
                n_chk_lvl   = r_k;
                if (r_scan_on) begin
                    mem_addr = r_scan_addr;
                    if (r_scan_addr == last_at(r_k)) begin
                        if (r_k == '0) begin
                            n_scan_on = 1'b0;
                        end else begin
                            n_k         = r_k - LVW'(1);
                            n_scan_addr = first_at(r_k - LVW'(1));
                        end
                    end else begin
                        n_scan_addr = r_scan_addr + IW'(1);
                    end
                end
                if (r_chk_valid && r_rdata) begin
                    n_idx       = r_chk_addr;
                    n_k         = r_chk_lvl;
                    n_scan_on   = 1'b0;
                    n_chk_valid = 1'b0;
                    n_state     = S_SPLIT_A;
                end else if (r_chk_valid && !r_scan_on) begin
                    n_chk_valid  = 1'b0;
                    n_res.status = ST_NO_FREE;
                    n_state      = S_DONE;
                end
            end
            S_SPLIT_A: begin
                mem_addr  = r_idx;
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                n_state   = (r_k == r_lvl) ? S_OFFSET : S_SPLIT_B;
            end
            S_SPLIT_B: begin
                mem_addr  = left + IW'(1);
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                n_idx     = left;
                n_k       = r_k + LVW'(1);
                n_state   = S_SPLIT_A;
            end
            S_OFFSET: begin
                n_prod  = prod_full[OFFSET_W-1:0];
                n_state = S_ADD;
            end
            S_ADD: begin
                n_res.status      = ST_OK;
                n_res.node_index  = INDEX_W'(r_idx);
                n_res.user_offset = r_prod + OFFSET_W'(HEADER_BYTES);
                n_res.block_level = LEVEL_W'(r_lvl);
                n_state           = S_DONE;
            end
            S_FREE_W: begin
                mem_addr  = r_idx;
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                n_state   = S_FREE_RD;
            end
            S_FREE_RD: begin
                if (r_idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    mem_addr = buddy;
                    n_state  = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (!r_rdata) begin
                    n_state = S_DONE;
                end else begin
                    mem_addr  = parent;
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                    n_state   = S_MERGE_A;
                end
            end
            S_MERGE_A: begin
                mem_addr  = r_idx;
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                n_state   = S_MERGE_B;
            end
            S_MERGE_B: begin
                mem_addr  = buddy;
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                n_idx     = parent;
                n_state   = S_FREE_RD;
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_scan_on   <= 1'b0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_scan_on   <= n_scan_on;
            r_chk_valid <= n_chk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total     <= n_total;
        r_cur       <= n_cur;
        r_lvl       <= n_lvl;
        r_k         <= n_k;
        r_idx       <= n_idx;
        r_scan_addr <= n_scan_addr;
        r_chk_addr  <= n_chk_addr;
        r_chk_lvl   <= n_chk_lvl;
        r_prod      <= n_prod;
        r_res       <= n_res;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = r_res;

    `BBA_ASSERT_IMP(a_split_depth, i_clk, i_rst_n, r_state == S_SPLIT_A || r_state == S_SPLIT_B, r_k <= r_lvl)
    `BBA_ASSERT_IMP(a_scan_drain, i_clk, i_rst_n, r_state == S_SCAN && !r_scan_on, r_chk_valid)
    `BBA_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, r_state == S_DONE && r_res.status != ST_OK, r_res.node_index == '0 && r_res.user_offset == '0 && r_res.block_level == '0)
    `BBA_ASSERT_NXT(a_done_release, i_clk, i_rst_n, r_state == S_DONE && i_ctl.take, r_state == S_IDLE)

endmodule

### rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: config registers and result register.
//
//  channel | handshake                     | payload
//  --------+-------------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_stall       | i_command, i_request_size, i_free_index
//  out     | o_out_valid / i_out_stall     | o_status, o_node_index, o_user_offset,
//          |                               | o_block_level
//  cfg     | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One transaction at a time, set by the single map memory port. An allocate sizes the
// request level by level, scans the map bits, splits down level by level and reckons
// the offset; with no free block it ends after the scan. A free marks the node, then
// merges with the free buddy level by level. Too large ends after sizing; bad index at once.
// After reset the map is cleared node by node; o_in_stall holds high.
// A stalled result sits in the output register while the next transaction starts.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_LEVELS   = 8,
    parameter int HEADER_BYTES = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [SIZE_W-1:0]      i_request_size,
    input  logic [INDEX_W-1:0]     i_free_index,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [INDEX_W-1:0]     o_node_index,
    output logic [OFFSET_W-1:0]    o_user_offset,
    output logic [LEVEL_W-1:0]     o_block_level,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [MBS_W-1:0] r_min_block_size;
    logic [NL_W-1:0]  r_num_levels;
    logic             r_out_valid;
    t_result          r_out;
    t_eng_ctl         eng_ctl;
    t_eng_stat        eng_stat;
    t_result          eng_result;
    logic             out_room;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_block_size <= MBS_RESET;
            r_num_levels     <= NL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_BLOCK:  r_min_block_size <= i_cfg_data[MBS_W-1:0];
                CFG_NUM_LEVELS: r_num_levels     <= i_cfg_data[NL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_room      = !r_out_valid || !i_out_stall;
    assign eng_ctl.start = i_in_valid && eng_stat.idle;
    assign eng_ctl.take  = out_room;
    assign o_in_stall    = !eng_stat.idle;

    bba_engine #(
        .MAX_LEVELS   (MAX_LEVELS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (eng_ctl),
        .i_command        (i_command),
        .i_request_size   (i_request_size),
        .i_free_index     (i_free_index),
        .i_min_block_size (r_min_block_size),
        .i_num_levels     (r_num_levels),
        .o_stat           (eng_stat),
        .o_result         (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_stat.done && out_room) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_stat.done && out_room) begin
            r_out <= eng_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_node_index  = r_out.node_index;
    assign o_user_offset = r_out.user_offset;
    assign o_block_level = r_out.block_level;

endmodule
